// ===== rtl/sst_pkg.sv =====
// ============================================================================
// Separation steering accumulator package
// Shared widths, register indexes, reset values, datapath op codes and the
// command and status structures between controller and datapath.
// ============================================================================
package sst_pkg;

   // Default geometry of the top level.
   localparam int POS_WIDTH_DEF = 32;
   localparam int ACC_WIDTH_DEF = 48;

   // Fixed widths of registers, results and the shared arithmetic units.
   localparam int RAD_W      = 31;
   localparam int STR_W      = 31;
   localparam int THR_W      = 16;
   localparam int CSR_DATA_W = 31;
   localparam int CSR_ADDR_W = 2;
   localparam int OUT_W      = 32;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 64;
   localparam int DIV_W      = 64;
   localparam int QUO_W      = 33;
   localparam int ROOT_W     = 32;
   localparam int AD_W       = 35;
   localparam int UNIT       = 65536;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_RADIUS    = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_STRENGTH  = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [RAD_W-1:0] RADIUS_RST   = 31'd131072;
   localparam logic [STR_W-1:0] STRENGTH_RST = 31'd65536;
   localparam logic [THR_W-1:0] THRESH_RST   = 16'd66;

   // Datapath operations.
   localparam int OP_W = 5;
   localparam logic [OP_W-1:0] OP_NOP   = 5'd0;
   localparam logic [OP_W-1:0] OP_LOAD  = 5'd1;
   localparam logic [OP_W-1:0] OP_ABS   = 5'd2;
   localparam logic [OP_W-1:0] OP_MXX   = 5'd3;
   localparam logic [OP_W-1:0] OP_MZZ   = 5'd4;
   localparam logic [OP_W-1:0] OP_MRR   = 5'd5;
   localparam logic [OP_W-1:0] OP_NEAR  = 5'd6;
   localparam logic [OP_W-1:0] OP_SQRT  = 5'd7;
   localparam logic [OP_W-1:0] OP_W_LEN = 5'd8;
   localparam logic [OP_W-1:0] OP_DIVF  = 5'd9;
   localparam logic [OP_W-1:0] OP_W_F   = 5'd10;
   localparam logic [OP_W-1:0] OP_MDX   = 5'd11;
   localparam logic [OP_W-1:0] OP_DIVX  = 5'd12;
   localparam logic [OP_W-1:0] OP_W_SX  = 5'd13;
   localparam logic [OP_W-1:0] OP_MDZ   = 5'd14;
   localparam logic [OP_W-1:0] OP_W_SZ  = 5'd15;
   localparam logic [OP_W-1:0] OP_PAR   = 5'd16;
   localparam logic [OP_W-1:0] OP_MAG   = 5'd17;
   localparam logic [OP_W-1:0] OP_SHIFT = 5'd18;
   localparam logic [OP_W-1:0] OP_RXX   = 5'd19;
   localparam logic [OP_W-1:0] OP_RZZ   = 5'd20;
   localparam logic [OP_W-1:0] OP_RADD  = 5'd21;
   localparam logic [OP_W-1:0] OP_RZERO = 5'd22;
   localparam logic [OP_W-1:0] OP_RMX   = 5'd23;
   localparam logic [OP_W-1:0] OP_DIVO  = 5'd24;
   localparam logic [OP_W-1:0] OP_W_OX  = 5'd25;
   localparam logic [OP_W-1:0] OP_RMZ   = 5'd26;
   localparam logic [OP_W-1:0] OP_W_OZ  = 5'd27;
   localparam logic [OP_W-1:0] OP_EMIT  = 5'd28;

   typedef struct packed {
      logic [OP_W-1:0] op;
   } cmd_type;

   typedef struct packed {
      logic has;
      logic last;
      logic in_rng;
      logic in_circle;
      logic near;
      logic big;
      logic zero_out;
      logic sqrt_done;
      logic div_done;
      logic out_free;
   } status_type;

endpackage

// ===== rtl/sst_div.sv =====
// ============================================================================
// Iterative divider
// Restoring division, one quotient bit per cycle, for quotients that are
// known to fit in QUO_W bits.
// ============================================================================
module sst_div (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic [sst_pkg::DIV_W-1:0] dividend,
   input  logic [sst_pkg::DIV_W-1:0] divisor,
   output logic                      done,
   output logic [sst_pkg::QUO_W-1:0] quotient
);
   localparam int CNT_W = $clog2(sst_pkg::QUO_W + 1);

   logic [sst_pkg::DIV_W-1:0] rem_ff, rem_in, dvs_ff, dvs_in, trial;
   logic [sst_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      busy_ff, busy_in, done_ff, done_in, ge;

   assign trial = {rem_ff[sst_pkg::DIV_W-2:0], quo_ff[sst_pkg::QUO_W-1]};
   assign ge    = trial >= dvs_ff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         // The high part of the dividend is already below the divisor.
         rem_in  = dividend >> sst_pkg::QUO_W;
         quo_in  = dividend[sst_pkg::QUO_W-1:0];
         dvs_in  = divisor;
         cnt_in  = CNT_W'(sst_pkg::QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? trial - dvs_ff : trial;
         quo_in = {quo_ff[sst_pkg::QUO_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/sst_sqrt.sv =====
// ============================================================================
// Iterative integer square root
// Digit-by-digit root of a 64-bit radicand, one root bit per cycle.
// ============================================================================
module sst_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [sst_pkg::PROD_W-1:0] radicand,
   output logic                       done,
   output logic [sst_pkg::ROOT_W-1:0] root
);
   localparam int REM_W = sst_pkg::ROOT_W + 2;
   localparam int TRY_W = REM_W + 2;
   localparam int CNT_W = $clog2(sst_pkg::ROOT_W + 1);

   logic [sst_pkg::PROD_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [sst_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [CNT_W-1:0]           cnt_ff, cnt_in;
   logic                       busy_ff, busy_in, done_ff, done_in, ge;
   logic [TRY_W-1:0]           cur, sub;

   assign cur = {rem_ff, rad_ff[sst_pkg::PROD_W-1:sst_pkg::PROD_W-2]};
   assign sub = {2'b00, root_ff, 2'b01};
   assign ge  = cur >= sub;

   always_comb begin
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
         cnt_in  = CNT_W'(sst_pkg::ROOT_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? REM_W'(cur - sub) : REM_W'(cur);
         root_in = {root_ff[sst_pkg::ROOT_W-2:0], ge};
         rad_in  = rad_ff << 2;
         cnt_in  = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ===== rtl/sst_datapath.sv =====
// ============================================================================
// Separation steering datapath
// Configuration registers, offset and accumulator registers, one shared
// multiplier, and the shared divider and square-root units.
// ============================================================================
module sst_datapath #(
   parameter int POS_WIDTH = sst_pkg::POS_WIDTH_DEF,
   parameter int ACC_WIDTH = sst_pkg::ACC_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  sst_pkg::cmd_type               cmd,
   output sst_pkg::status_type            status,
   input  logic signed [POS_WIDTH-1:0]    self_x,
   input  logic signed [POS_WIDTH-1:0]    self_z,
   input  logic signed [POS_WIDTH-1:0]    other_x,
   input  logic signed [POS_WIDTH-1:0]    other_z,
   input  logic                           has_neighbor,
   input  logic                           last_item,
   input  logic                           csr_we,
   input  logic [sst_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sst_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                           rsp_tready,
   output logic                           rsp_tvalid,
   output logic [sst_pkg::OUT_W-1:0]      steer_x,
   output logic [sst_pkg::OUT_W-1:0]      steer_z
);
   localparam int DW  = POS_WIDTH + 1;
   localparam int CW  = (DW > sst_pkg::RAD_W) ? DW : sst_pkg::RAD_W;
   localparam int MW  = ACC_WIDTH - 1;
   localparam int MCW = (MW > sst_pkg::MUL_W) ? MW : sst_pkg::MUL_W;
   localparam int SW  = ((ACC_WIDTH > sst_pkg::AD_W) ? ACC_WIDTH : sst_pkg::AD_W) + 1;
   localparam logic signed [SW-1:0] SAT_HI =
      {{(SW-ACC_WIDTH+1){1'b0}}, {(ACC_WIDTH-1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = -SAT_HI;
   localparam logic signed [sst_pkg::AD_W-1:0] UNIT_ADD = sst_pkg::AD_W'(sst_pkg::UNIT);

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH-1:0]     a,
      input logic signed [sst_pkg::AD_W-1:0] b
   );
      logic signed [SW-1:0] s;
      s = SW'(a) + SW'(b);
      if (s > SAT_HI)
         s = SAT_HI;
      else if (s < SAT_LO)
         s = SAT_LO;
      return ACC_WIDTH'(s);
   endfunction

   logic [sst_pkg::RAD_W-1:0]  radius_ff, radius_in;
   logic [sst_pkg::STR_W-1:0]  strength_ff, strength_in;
   logic [sst_pkg::THR_W-1:0]  thresh_ff, thresh_in;
   logic signed [DW-1:0]       dx_ff, dx_in, dz_ff, dz_in;
   logic                       has_ff, has_in, last_ff, last_in;
   logic [DW-1:0]              ax_ff, ax_in, az_ff, az_in;
   logic [sst_pkg::PROD_W-1:0] prod_ff, prod_in, d2_ff, d2_in;
   logic [sst_pkg::ROOT_W-1:0] len_ff, len_in;
   logic [sst_pkg::MUL_W-1:0]  f_ff, f_in;
   logic signed [ACC_WIDTH-1:0] sum_x_ff, sum_x_in, sum_z_ff, sum_z_in;
   logic                       parity_ff, parity_in, kflag_ff, kflag_in;
   logic [MW-1:0]              mx_ff, mx_in, mz_ff, mz_in;
   logic [sst_pkg::OUT_W-1:0]  res_x_ff, res_x_in, res_z_ff, res_z_in;
   logic [sst_pkg::OUT_W-1:0]  out_x_ff, out_x_in, out_z_ff, out_z_in;
   logic                       out_valid_ff, out_valid_in;

   logic [CW-1:0]              ax_ext, az_ext, rad_ext;
   logic [MCW-1:0]             mx_ext, mz_ext;
   logic [sst_pkg::MUL_W-1:0]  mul_a, mul_b;
   logic [sst_pkg::PROD_W-1:0] product;
   logic                       div_start, div_done, sqrt_done;
   logic [sst_pkg::DIV_W-1:0]  div_num, div_den;
   logic [sst_pkg::QUO_W-1:0]  div_quo;
   logic [sst_pkg::ROOT_W-1:0] sqrt_root;
   logic [sst_pkg::RAD_W-1:0]  r_minus_len;
   logic signed [sst_pkg::AD_W-1:0] q_add, qx_add, qz_add;
   logic [sst_pkg::OUT_W-1:0]  q_out;

   assign ax_ext  = CW'(ax_ff);
   assign az_ext  = CW'(az_ff);
   assign rad_ext = CW'(radius_ff);
   assign mx_ext  = MCW'(mx_ff);
   assign mz_ext  = MCW'(mz_ff);

   // Shared multiplier: operands chosen by the current operation.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         sst_pkg::OP_MXX: begin
            mul_a = sst_pkg::MUL_W'(ax_ext[sst_pkg::RAD_W-1:0]);
            mul_b = sst_pkg::MUL_W'(ax_ext[sst_pkg::RAD_W-1:0]);
         end
         sst_pkg::OP_MZZ: begin
            mul_a = sst_pkg::MUL_W'(az_ext[sst_pkg::RAD_W-1:0]);
            mul_b = sst_pkg::MUL_W'(az_ext[sst_pkg::RAD_W-1:0]);
         end
         sst_pkg::OP_MRR: begin
            mul_a = sst_pkg::MUL_W'(radius_ff);
            mul_b = sst_pkg::MUL_W'(radius_ff);
         end
         sst_pkg::OP_MDX: begin
            mul_a = sst_pkg::MUL_W'(ax_ext[sst_pkg::RAD_W-1:0]);
            mul_b = f_ff;
         end
         sst_pkg::OP_MDZ: begin
            mul_a = sst_pkg::MUL_W'(az_ext[sst_pkg::RAD_W-1:0]);
            mul_b = f_ff;
         end
         sst_pkg::OP_RXX: begin
            mul_a = sst_pkg::MUL_W'(mx_ext[sst_pkg::RAD_W-1:0]);
            mul_b = sst_pkg::MUL_W'(mx_ext[sst_pkg::RAD_W-1:0]);
         end
         sst_pkg::OP_RZZ: begin
            mul_a = sst_pkg::MUL_W'(mz_ext[sst_pkg::RAD_W-1:0]);
            mul_b = sst_pkg::MUL_W'(mz_ext[sst_pkg::RAD_W-1:0]);
         end
         sst_pkg::OP_RMX: begin
            mul_a = sst_pkg::MUL_W'(mx_ext[sst_pkg::RAD_W-1:0]);
            mul_b = sst_pkg::MUL_W'(strength_ff);
         end
         sst_pkg::OP_RMZ: begin
            mul_a = sst_pkg::MUL_W'(mz_ext[sst_pkg::RAD_W-1:0]);
            mul_b = sst_pkg::MUL_W'(strength_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign product = sst_pkg::PROD_W'(mul_a) * sst_pkg::PROD_W'(mul_b);

   // Divider operands.
   assign r_minus_len = radius_ff - len_ff[sst_pkg::RAD_W-1:0];
   assign div_start   = (cmd.op == sst_pkg::OP_DIVF) || (cmd.op == sst_pkg::OP_DIVX) ||
                        (cmd.op == sst_pkg::OP_DIVO);

   always_comb begin
      div_num = prod_ff;
      div_den = sst_pkg::DIV_W'(len_ff);
      case (cmd.op)
         sst_pkg::OP_DIVF: begin
            div_num = {1'b0, r_minus_len, 32'd0};
            div_den = sst_pkg::DIV_W'(radius_ff);
         end
         sst_pkg::OP_DIVX: begin
            div_num = prod_ff;
            div_den = d2_ff;
         end
         default: begin
            div_num = prod_ff;
            div_den = sst_pkg::DIV_W'(len_ff);
         end
      endcase
   end

   sst_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   sst_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.op == sst_pkg::OP_SQRT),
      .radicand (d2_ff),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   assign q_add  = $signed(sst_pkg::AD_W'(div_quo));
   assign qx_add = dx_ff[DW-1] ? -q_add : q_add;
   assign qz_add = dz_ff[DW-1] ? -q_add : q_add;
   assign q_out  = div_quo[sst_pkg::OUT_W-1:0];

   always_comb begin
      radius_in    = radius_ff;
      strength_in  = strength_ff;
      thresh_in    = thresh_ff;
      dx_in        = dx_ff;
      dz_in        = dz_ff;
      has_in       = has_ff;
      last_in      = last_ff;
      ax_in        = ax_ff;
      az_in        = az_ff;
      prod_in      = prod_ff;
      d2_in        = d2_ff;
      len_in       = len_ff;
      f_in         = f_ff;
      sum_x_in     = sum_x_ff;
      sum_z_in     = sum_z_ff;
      parity_in    = parity_ff;
      kflag_in     = kflag_ff;
      mx_in        = mx_ff;
      mz_in        = mz_ff;
      res_x_in     = res_x_ff;
      res_z_in     = res_z_ff;
      out_x_in     = out_x_ff;
      out_z_in     = out_z_ff;
      out_valid_in = out_valid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_addr)
            sst_pkg::CSR_RADIUS:    radius_in   = csr_wdata[sst_pkg::RAD_W-1:0];
            sst_pkg::CSR_STRENGTH:  strength_in = csr_wdata[sst_pkg::STR_W-1:0];
            sst_pkg::CSR_THRESHOLD: thresh_in   = csr_wdata[sst_pkg::THR_W-1:0];
            default:                radius_in   = radius_ff;
         endcase
      end

      case (cmd.op)
         sst_pkg::OP_LOAD: begin
            dx_in   = DW'(self_x) - DW'(other_x);
            dz_in   = DW'(self_z) - DW'(other_z);
            has_in  = has_neighbor;
            last_in = last_item;
         end
         sst_pkg::OP_ABS: begin
            ax_in = dx_ff[DW-1] ? DW'(-dx_ff) : DW'(dx_ff);
            az_in = dz_ff[DW-1] ? DW'(-dz_ff) : DW'(dz_ff);
         end
         sst_pkg::OP_MXX: prod_in = product;
         sst_pkg::OP_MZZ: begin
            d2_in   = prod_ff;
            prod_in = product;
         end
         sst_pkg::OP_MRR: begin
            d2_in   = d2_ff + prod_ff;
            prod_in = product;
         end
         sst_pkg::OP_NEAR: begin
            sum_x_in = sat_add(sum_x_ff, parity_ff ? -UNIT_ADD : UNIT_ADD);
            sum_z_in = sat_add(sum_z_ff, parity_ff ? UNIT_ADD : -UNIT_ADD);
         end
         sst_pkg::OP_W_LEN: if (sqrt_done) len_in = sqrt_root;
         sst_pkg::OP_W_F:   if (div_done) f_in = div_quo[sst_pkg::MUL_W-1:0];
         sst_pkg::OP_MDX:   prod_in = product;
         sst_pkg::OP_W_SX:  if (div_done) sum_x_in = sat_add(sum_x_ff, qx_add);
         sst_pkg::OP_MDZ:   prod_in = product;
         sst_pkg::OP_W_SZ:  if (div_done) sum_z_in = sat_add(sum_z_ff, qz_add);
         sst_pkg::OP_PAR:   parity_in = !parity_ff;
         sst_pkg::OP_MAG: begin
            mx_in    = MW'(sum_x_ff[ACC_WIDTH-1] ? -sum_x_ff : sum_x_ff);
            mz_in    = MW'(sum_z_ff[ACC_WIDTH-1] ? -sum_z_ff : sum_z_ff);
            kflag_in = 1'b0;
         end
         sst_pkg::OP_SHIFT: begin
            mx_in    = mx_ff >> 1;
            mz_in    = mz_ff >> 1;
            kflag_in = 1'b1;
         end
         sst_pkg::OP_RXX: prod_in = product;
         sst_pkg::OP_RZZ: begin
            d2_in   = prod_ff;
            prod_in = product;
         end
         sst_pkg::OP_RADD: d2_in = d2_ff + prod_ff;
         sst_pkg::OP_RZERO: begin
            res_x_in = '0;
            res_z_in = '0;
         end
         sst_pkg::OP_RMX:  prod_in = product;
         sst_pkg::OP_W_OX: if (div_done) res_x_in = sum_x_ff[ACC_WIDTH-1] ? -q_out : q_out;
         sst_pkg::OP_RMZ:  prod_in = product;
         sst_pkg::OP_W_OZ: if (div_done) res_z_in = sum_z_ff[ACC_WIDTH-1] ? -q_out : q_out;
         sst_pkg::OP_EMIT: begin
            out_x_in     = res_x_ff;
            out_z_in     = res_z_ff;
            out_valid_in = 1'b1;
            sum_x_in     = '0;
            sum_z_in     = '0;
            parity_in    = 1'b0;
         end
         default: prod_in = prod_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff    <= sst_pkg::RADIUS_RST;
         strength_ff  <= sst_pkg::STRENGTH_RST;
         thresh_ff    <= sst_pkg::THRESH_RST;
         sum_x_ff     <= '0;
         sum_z_ff     <= '0;
         parity_ff    <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         radius_ff    <= radius_in;
         strength_ff  <= strength_in;
         thresh_ff    <= thresh_in;
         sum_x_ff     <= sum_x_in;
         sum_z_ff     <= sum_z_in;
         parity_ff    <= parity_in;
         out_valid_ff <= out_valid_in;
      end
      dx_ff    <= dx_in;
      dz_ff    <= dz_in;
      has_ff   <= has_in;
      last_ff  <= last_in;
      ax_ff    <= ax_in;
      az_ff    <= az_in;
      prod_ff  <= prod_in;
      d2_ff    <= d2_in;
      len_ff   <= len_in;
      f_ff     <= f_in;
      kflag_ff <= kflag_in;
      mx_ff    <= mx_in;
      mz_ff    <= mz_in;
      res_x_ff <= res_x_in;
      res_z_ff <= res_z_in;
      out_x_ff <= out_x_in;
      out_z_ff <= out_z_in;
   end

   assign status.has       = has_ff;
   assign status.last      = last_ff;
   assign status.in_rng    = (ax_ext < rad_ext) && (az_ext < rad_ext);
   assign status.in_circle = d2_ff < prod_ff;
   assign status.near      = (d2_ff == '0) ||
                             (d2_ff < sst_pkg::PROD_W'({thresh_ff, 16'd0}));
   assign status.big       = (mx_ext[MCW-1:31] != '0) || (mz_ext[MCW-1:31] != '0);
   assign status.zero_out  = (len_ff == '0) ||
                             (!kflag_ff && (len_ff <= sst_pkg::ROOT_W'(thresh_ff)));
   assign status.sqrt_done = sqrt_done;
   assign status.div_done  = div_done;
   assign status.out_free  = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign steer_x    = out_x_ff;
   assign steer_z    = out_z_ff;

   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.op == sst_pkg::OP_EMIT |=> sum_x_ff == '0 && sum_z_ff == '0 && !parity_ff)
      else $error("run state not cleared after a result");

   a_emit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.op == sst_pkg::OP_EMIT |-> (!out_valid_ff || rsp_tready))
      else $error("result overwrote a waiting transfer");

   a_shift_done: assert property (@(posedge clock) disable iff (reset)
      cmd.op == sst_pkg::OP_RXX |-> (mx_ext[MCW-1:31] == '0 && mz_ext[MCW-1:31] == '0))
      else $error("sum magnitude not reduced below 2^31");

endmodule

// ===== rtl/sst_ctrl.sv =====
// ============================================================================
// Separation steering controller
// Sequences the datapath through the per-neighbour and end-of-run steps.
// ============================================================================
module sst_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  sst_pkg::status_type status,
   output sst_pkg::cmd_type    cmd
);
   localparam int ST_W = 6;
   localparam logic [ST_W-1:0] ST_IDLE    = 6'd0;
   localparam logic [ST_W-1:0] ST_ABS     = 6'd1;
   localparam logic [ST_W-1:0] ST_TEST    = 6'd2;
   localparam logic [ST_W-1:0] ST_MXX     = 6'd3;
   localparam logic [ST_W-1:0] ST_MZZ     = 6'd4;
   localparam logic [ST_W-1:0] ST_MRR     = 6'd5;
   localparam logic [ST_W-1:0] ST_CMP     = 6'd6;
   localparam logic [ST_W-1:0] ST_NEAR    = 6'd7;
   localparam logic [ST_W-1:0] ST_SQRT    = 6'd8;
   localparam logic [ST_W-1:0] ST_SQRT_W  = 6'd9;
   localparam logic [ST_W-1:0] ST_DIVF    = 6'd10;
   localparam logic [ST_W-1:0] ST_DIVF_W  = 6'd11;
   localparam logic [ST_W-1:0] ST_MDX     = 6'd12;
   localparam logic [ST_W-1:0] ST_DIVX    = 6'd13;
   localparam logic [ST_W-1:0] ST_DIVX_W  = 6'd14;
   localparam logic [ST_W-1:0] ST_MDZ     = 6'd15;
   localparam logic [ST_W-1:0] ST_DIVZ    = 6'd16;
   localparam logic [ST_W-1:0] ST_DIVZ_W  = 6'd17;
   localparam logic [ST_W-1:0] ST_PAR     = 6'd18;
   localparam logic [ST_W-1:0] ST_MAG     = 6'd19;
   localparam logic [ST_W-1:0] ST_SHIFT   = 6'd20;
   localparam logic [ST_W-1:0] ST_RXX     = 6'd21;
   localparam logic [ST_W-1:0] ST_RZZ     = 6'd22;
   localparam logic [ST_W-1:0] ST_RADD    = 6'd23;
   localparam logic [ST_W-1:0] ST_RSQRT   = 6'd24;
   localparam logic [ST_W-1:0] ST_RSQRT_W = 6'd25;
   localparam logic [ST_W-1:0] ST_RCHK    = 6'd26;
   localparam logic [ST_W-1:0] ST_RZERO   = 6'd27;
   localparam logic [ST_W-1:0] ST_RMX     = 6'd28;
   localparam logic [ST_W-1:0] ST_RDIVX   = 6'd29;
   localparam logic [ST_W-1:0] ST_RDIVX_W = 6'd30;
   localparam logic [ST_W-1:0] ST_RMZ     = 6'd31;
   localparam logic [ST_W-1:0] ST_RDIVZ   = 6'd32;
   localparam logic [ST_W-1:0] ST_RDIVZ_W = 6'd33;
   localparam logic [ST_W-1:0] ST_EMIT    = 6'd34;

   logic [ST_W-1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.op     = sst_pkg::OP_NOP;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = sst_pkg::OP_LOAD;
               state_in = ST_ABS;
            end
         end
         ST_ABS: begin
            cmd.op   = sst_pkg::OP_ABS;
            state_in = ST_TEST;
         end
         ST_TEST: begin
            if (!status.has)
               state_in = status.last ? ST_MAG : ST_IDLE;
            else if (!status.in_rng)
               state_in = ST_PAR;
            else
               state_in = ST_MXX;
         end
         ST_MXX: begin
            cmd.op   = sst_pkg::OP_MXX;
            state_in = ST_MZZ;
         end
         ST_MZZ: begin
            cmd.op   = sst_pkg::OP_MZZ;
            state_in = ST_MRR;
         end
         ST_MRR: begin
            cmd.op   = sst_pkg::OP_MRR;
            state_in = ST_CMP;
         end
         ST_CMP: begin
            if (!status.in_circle)
               state_in = ST_PAR;
            else if (status.near)
               state_in = ST_NEAR;
            else
               state_in = ST_SQRT;
         end
         ST_NEAR: begin
            cmd.op   = sst_pkg::OP_NEAR;
            state_in = ST_PAR;
         end
         ST_SQRT: begin
            cmd.op   = sst_pkg::OP_SQRT;
            state_in = ST_SQRT_W;
         end
         ST_SQRT_W: begin
            cmd.op = sst_pkg::OP_W_LEN;
            if (status.sqrt_done) state_in = ST_DIVF;
         end
         ST_DIVF: begin
            cmd.op   = sst_pkg::OP_DIVF;
            state_in = ST_DIVF_W;
         end
         ST_DIVF_W: begin
            cmd.op = sst_pkg::OP_W_F;
            if (status.div_done) state_in = ST_MDX;
         end
         ST_MDX: begin
            cmd.op   = sst_pkg::OP_MDX;
            state_in = ST_DIVX;
         end
         ST_DIVX: begin
            cmd.op   = sst_pkg::OP_DIVX;
            state_in = ST_DIVX_W;
         end
         ST_DIVX_W: begin
            cmd.op = sst_pkg::OP_W_SX;
            if (status.div_done) state_in = ST_MDZ;
         end
         ST_MDZ: begin
            cmd.op   = sst_pkg::OP_MDZ;
            state_in = ST_DIVZ;
         end
         ST_DIVZ: begin
            cmd.op   = sst_pkg::OP_DIVX;
            state_in = ST_DIVZ_W;
         end
         ST_DIVZ_W: begin
            cmd.op = sst_pkg::OP_W_SZ;
            if (status.div_done) state_in = ST_PAR;
         end
         ST_PAR: begin
            cmd.op   = sst_pkg::OP_PAR;
            state_in = status.last ? ST_MAG : ST_IDLE;
         end
         ST_MAG: begin
            cmd.op   = sst_pkg::OP_MAG;
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (status.big)
               cmd.op = sst_pkg::OP_SHIFT;
            else
               state_in = ST_RXX;
         end
         ST_RXX: begin
            cmd.op   = sst_pkg::OP_RXX;
            state_in = ST_RZZ;
         end
         ST_RZZ: begin
            cmd.op   = sst_pkg::OP_RZZ;
            state_in = ST_RADD;
         end
         ST_RADD: begin
            cmd.op   = sst_pkg::OP_RADD;
            state_in = ST_RSQRT;
         end
         ST_RSQRT: begin
            cmd.op   = sst_pkg::OP_SQRT;
            state_in = ST_RSQRT_W;
         end
         ST_RSQRT_W: begin
            cmd.op = sst_pkg::OP_W_LEN;
            if (status.sqrt_done) state_in = ST_RCHK;
         end
         ST_RCHK: begin
            state_in = status.zero_out ? ST_RZERO : ST_RMX;
         end
         ST_RZERO: begin
            cmd.op   = sst_pkg::OP_RZERO;
            state_in = ST_EMIT;
         end
         ST_RMX: begin
            cmd.op   = sst_pkg::OP_RMX;
            state_in = ST_RDIVX;
         end
         ST_RDIVX: begin
            cmd.op   = sst_pkg::OP_DIVO;
            state_in = ST_RDIVX_W;
         end
         ST_RDIVX_W: begin
            cmd.op = sst_pkg::OP_W_OX;
            if (status.div_done) state_in = ST_RMZ;
         end
         ST_RMZ: begin
            cmd.op   = sst_pkg::OP_RMZ;
            state_in = ST_RDIVZ;
         end
         ST_RDIVZ: begin
            cmd.op   = sst_pkg::OP_DIVO;
            state_in = ST_RDIVZ_W;
         end
         ST_RDIVZ_W: begin
            cmd.op = sst_pkg::OP_W_OZ;
            if (status.div_done) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.op   = sst_pkg::OP_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_sqrt_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.sqrt_done |-> (state_ff == ST_SQRT_W || state_ff == ST_RSQRT_W))
      else $error("square root finished outside a wait state");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == ST_DIVF_W || state_ff == ST_DIVX_W ||
                           state_ff == ST_DIVZ_W || state_ff == ST_RDIVX_W ||
                           state_ff == ST_RDIVZ_W))
      else $error("division finished outside a wait state");

   a_parity_has: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PAR |-> status.has)
      else $error("parity advanced for an item without a neighbour");

endmodule

// ===== rtl/separation_steering_accumulator.sv =====
// ============================================================================
// Separation steering accumulator
// A weighted neighbour passes through the shared square-root unit (32 steps)
// and makes three passes through the shared divider (33 steps each);
// skipped or near-coincident neighbours use neither unit.
// A final item adds the length of the sum, two divisions unless the result
// is zeroed, and the output transfer. One item is processed at a time.
// Reset is synchronous: configuration registers return to their defaults and sums clear.
// ============================================================================
module separation_steering_accumulator #(
   parameter int POS_WIDTH = sst_pkg::POS_WIDTH_DEF,
   parameter int ACC_WIDTH = sst_pkg::ACC_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // Neighbour stream.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // Fields from bit 0 up: self_x, self_z, other_x, other_z, zero padding.
   input  logic [((4*POS_WIDTH+7)/8)*8-1:0] req_tdata,
   // Fields from bit 0 up: has_neighbor.
   input  logic [0:0]                     req_tuser,
   input  logic                           req_tlast,
   // Steering result stream.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // Fields from bit 0 up: steer_x, steer_z.
   output logic [2*sst_pkg::OUT_W-1:0]    rsp_tdata,
   // Configuration writes.
   input  logic                           csr_we,
   input  logic [sst_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [sst_pkg::CSR_DATA_W-1:0] csr_wdata
);
   // The controller and datapath talk only through the command and status
   // structures. The datapath holds the configuration, the run sums and the
   // output register, so a finished result can wait for its transfer while
   // the next run's neighbours are already being taken in.

   sst_pkg::cmd_type    cmd;
   sst_pkg::status_type status;

   logic signed [POS_WIDTH-1:0] self_x, self_z, other_x, other_z;
   logic [sst_pkg::OUT_W-1:0]   steer_x, steer_z;

   assign self_x  = req_tdata[POS_WIDTH-1:0];
   assign self_z  = req_tdata[2*POS_WIDTH-1:POS_WIDTH];
   assign other_x = req_tdata[3*POS_WIDTH-1:2*POS_WIDTH];
   assign other_z = req_tdata[4*POS_WIDTH-1:3*POS_WIDTH];

   // Input transfers are taken only while the controller is waiting for an
   // item; each transfer is then worked through the datapath step by step.
   sst_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   sst_datapath #(
      .POS_WIDTH (POS_WIDTH),
      .ACC_WIDTH (ACC_WIDTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .self_x       (self_x),
      .self_z       (self_z),
      .other_x      (other_x),
      .other_z      (other_z),
      .has_neighbor (req_tuser[0]),
      .last_item    (req_tlast),
      .csr_we       (csr_we),
      .csr_addr     (csr_addr),
      .csr_wdata    (csr_wdata),
      .rsp_tready   (rsp_tready),
      .rsp_tvalid   (rsp_tvalid),
      .steer_x      (steer_x),
      .steer_z      (steer_z)
   );

   // The result transfer carries both components side by side.
   assign rsp_tdata = {steer_z, steer_x};

endmodule

// ===== verif/separation_steering_accumulator_tb.sv =====
// ============================================================================
// Separation steering accumulator testbench
// Drives runs of neighbour transfers into the block and predicts each
// steering result with a fixed-point model of its own. Every result transfer
// is checked against the oldest prediction. The run covers several register
// settings, a long receiver hold-off and a drained pause in the input.
// ============================================================================
module separation_steering_accumulator_tb;

   localparam int POS_W = sst_pkg::POS_WIDTH_DEF;
   localparam int ACC_W = sst_pkg::ACC_WIDTH_DEF;
   localparam int REQ_W = ((4*POS_W+7)/8)*8;
   localparam int SETTLE_CYCLES = 400;

   typedef struct packed {
      logic [POS_W-1:0] self_x;
      logic [POS_W-1:0] self_z;
      logic [POS_W-1:0] other_x;
      logic [POS_W-1:0] other_z;
      logic             has_neighbor;
      logic             last_item;
   } neighbour_type;

   typedef struct packed {
      logic [sst_pkg::OUT_W-1:0] steer_x;
      logic [sst_pkg::OUT_W-1:0] steer_z;
   } steer_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic [0:0] req_tuser;
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [2*sst_pkg::OUT_W-1:0] rsp_tdata;
   logic csr_we;
   logic [sst_pkg::CSR_ADDR_W-1:0] csr_addr;
   logic [sst_pkg::CSR_DATA_W-1:0] csr_wdata;

   // Model copy of the registers and of the run state.
   longint unsigned radius_q;
   longint unsigned strength_q;
   longint unsigned threshold_q;
   longint sum_x_q;
   longint sum_z_q;
   bit parity_q;

   steer_type steer_expected[$];
   int error_count;
   int items_sent;
   int results_checked;
   int runs_sent;
   bit no_idle;
   int hold_requests;
   int holds_served;
   int hold_left;

   separation_steering_accumulator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // The whole run is bounded; a hang ends here as a failure.
   initial begin
      #40000000;
      $display("TB_ERROR");
      $finish;
   end

   // Integer square root, rounded down, by the digit-by-digit method.
   function automatic longint unsigned floor_root(longint unsigned v);
      longint unsigned rest;
      longint unsigned root;
      longint unsigned trial;
      rest = v;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = (root << (b + 1)) + (64'd1 << (2 * b));
         if (rest >= trial) begin
            rest -= trial;
            root |= 64'd1 << b;
         end
      end
      return root;
   endfunction

   // Accumulator add that clamps symmetrically at the 48-bit limits.
   function automatic longint clamped_add(longint a, longint b);
      longint top;
      longint total;
      top = (longint'(1) <<< (ACC_W - 1)) - 1;
      total = a + b;
      if (total > top) return top;
      if (total < -top) return -top;
      return total;
   endfunction

   function automatic longint signed_quotient(longint d, longint unsigned f,
                                              longint unsigned d2);
      longint unsigned q;
      q = ((d < 0) ? longint'(-d) : d) * f / d2;
      return (d < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic logic [sst_pkg::OUT_W-1:0] scaled_component(
      longint s, longint unsigned m, longint unsigned len);
      longint unsigned q;
      longint v;
      q = m * strength_q / len;
      v = (s < 0) ? -longint'(q) : longint'(q);
      return v[sst_pkg::OUT_W-1:0];
   endfunction

   // Folds one accepted neighbour into the model sums and, on the last
   // transfer of a run, queues the predicted steering vector.
   task automatic accumulate_separation(input neighbour_type n);
      longint dx;
      longint dz;
      longint unsigned ax;
      longint unsigned az;
      longint unsigned d2;
      longint unsigned len;
      longint unsigned f;
      longint unsigned mx;
      longint unsigned mz;
      longint unit_step;
      int k;
      steer_type r;
      if (n.has_neighbor) begin
         dx = longint'($signed(n.self_x)) - longint'($signed(n.other_x));
         dz = longint'($signed(n.self_z)) - longint'($signed(n.other_z));
         ax = (dx < 0) ? -dx : dx;
         az = (dz < 0) ? -dz : dz;
         if (ax < radius_q && az < radius_q) begin
            d2 = ax * ax + az * az;
            if (d2 < radius_q * radius_q) begin
               if (d2 == 0 || d2 < (threshold_q << 16)) begin
                  // Coincident and near neighbours push along a fixed diagonal whose
                  // sign flips with the neighbour's position in the run.
                  unit_step = parity_q ? -longint'(sst_pkg::UNIT) : longint'(sst_pkg::UNIT);
                  sum_x_q = clamped_add(sum_x_q, unit_step);
                  sum_z_q = clamped_add(sum_z_q, -unit_step);
               end else begin
                  len = floor_root(d2);
                  f = ((radius_q - len) << 32) / radius_q;
                  sum_x_q = clamped_add(sum_x_q, signed_quotient(dx, f, d2));
                  sum_z_q = clamped_add(sum_z_q, signed_quotient(dz, f, d2));
               end
            end
         end
         parity_q = ~parity_q;
      end
      if (n.last_item) begin
         mx = (sum_x_q < 0) ? -sum_x_q : sum_x_q;
         mz = (sum_z_q < 0) ? -sum_z_q : sum_z_q;
         k = 0;
         while ((mx >> k) >= (64'd1 << 31) || (mz >> k) >= (64'd1 << 31)) k++;
         mx >>= k;
         mz >>= k;
         len = floor_root(mx * mx + mz * mz);
         if (len == 0 || (k == 0 && len <= threshold_q)) begin
            r = '0;
         end else begin
            r.steer_x = scaled_component(sum_x_q, mx, len);
            r.steer_z = scaled_component(sum_z_q, mz, len);
         end
         steer_expected.push_back(r);
         sum_x_q = 0;
         sum_z_q = 0;
         parity_q = 1'b0;
         runs_sent++;
      end
   endtask

   task automatic report_mismatch(input string what,
                                  input logic [sst_pkg::OUT_W-1:0] got,
                                  input logic [sst_pkg::OUT_W-1:0] want);
      $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      error_count++;
   endtask

   // Result checker: compares every result transfer with the oldest prediction.
   always @(posedge clock) begin
      steer_type got;
      steer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.steer_x = rsp_tdata[sst_pkg::OUT_W-1:0];
         got.steer_z = rsp_tdata[2*sst_pkg::OUT_W-1:sst_pkg::OUT_W];
         if (steer_expected.size() == 0) begin
            report_mismatch("unexpected result", got.steer_x, '0);
         end else begin
            want = steer_expected.pop_front();
            if (got.steer_x !== want.steer_x)
               report_mismatch("steer_x", got.steer_x, want.steer_x);
            if (got.steer_z !== want.steer_z)
               report_mismatch("steer_z", got.steer_z, want.steer_z);
         end
         results_checked++;
      end
   end

   // Receiver: random stalls, plus a long hold-off when one is requested.
   always @(negedge clock) begin
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left = 3000;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 14);
      end
   end

   // Offers one neighbour and waits for its transfer. The valid stays high
   // afterwards, until the next call or release_input drives it again.
   task automatic send_neighbour(input neighbour_type n);
      @(negedge clock);
      if (!no_idle && $urandom_range(0, 99) < 14) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata = {n.other_z, n.other_x, n.self_z, n.self_x};
      req_tuser = n.has_neighbor;
      req_tlast = n.last_item;
      do @(posedge clock); while (!req_tready);
      accumulate_separation(n);
      items_sent++;
   endtask

   task automatic release_input();
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // Waits until every prediction has been matched, then lets any neighbour
   // still in the arithmetic units finish.
   task automatic wait_drained();
      release_input();
      while (steer_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [sst_pkg::CSR_ADDR_W-1:0] idx,
                                 input longint unsigned value);
      wait_drained();
      @(negedge clock);
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = value[sst_pkg::CSR_DATA_W-1:0];
      @(negedge clock);
      csr_we = 1'b0;
      case (idx)
         sst_pkg::CSR_RADIUS:    radius_q = value & 64'h7FFF_FFFF;
         sst_pkg::CSR_STRENGTH:  strength_q = value & 64'h7FFF_FFFF;
         sst_pkg::CSR_THRESHOLD: threshold_q = value & 64'hFFFF;
         default: ;
      endcase
   endtask

   function automatic neighbour_type make_neighbour(input logic [POS_W-1:0] sx,
                                                    input logic [POS_W-1:0] sz,
                                                    input longint dx, input longint dz,
                                                    input bit has, input bit last);
      neighbour_type n;
      n.self_x = sx;
      n.self_z = sz;
      n.other_x = sx - dx[POS_W-1:0];
      n.other_z = sz - dz[POS_W-1:0];
      n.has_neighbor = has;
      n.last_item = last;
      return n;
   endfunction

   // Picks an offset component: mostly inside the radius at a random scale.
   function automatic longint random_offset();
      longint unsigned lim;
      longint mag;
      lim = (radius_q > 0) ? radius_q - 1 : 0;
      lim = lim >> $urandom_range(0, 20);
      mag = $urandom_range(0, lim[31:0]);
      return $urandom_range(0, 1) ? -mag : mag;
   endfunction

   // One run of random neighbours with a shared agent position.
   task automatic send_random_run(input int len);
      logic [POS_W-1:0] sx;
      logic [POS_W-1:0] sz;
      neighbour_type n;
      int pick;
      sx = $urandom;
      sz = $urandom;
      for (int i = 0; i < len; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            n = make_neighbour(sx, sz, 0, 0, 1'b0, i == len - 1);
            n.other_x = $urandom;
            n.other_z = $urandom;
         end else if (pick < 22) begin
            n = make_neighbour(sx, sz, $urandom_range(0, 300) - 150,
                               $urandom_range(0, 300) - 150, 1'b1, i == len - 1);
         end else if (pick < 32) begin
            n = make_neighbour(sx, sz, 0, 0, 1'b1, i == len - 1);
            n.other_x = $urandom;
            n.other_z = $urandom;
         end else begin
            n = make_neighbour(sx, sz, random_offset(), random_offset(), 1'b1,
                               i == len - 1);
         end
         send_neighbour(n);
      end
   endtask

   task automatic test_random_runs(input int item_goal);
      int goal;
      goal = items_sent + item_goal;
      while (items_sent < goal)
         send_random_run(($urandom_range(0, 9) == 0) ? $urandom_range(7, 14)
                                                     : $urandom_range(1, 5));
   endtask

   // Directed cases: empty runs, extreme positions, coincident neighbours
   // with both parities, weighted neighbours and the shifted result path.
   task automatic test_directed();
      send_neighbour(make_neighbour('0, '0, 0, 0, 1'b0, 1'b1));
      send_neighbour(make_neighbour('0, '0, 0, 0, 1'b1, 1'b1));
      send_neighbour(make_neighbour(32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 1'b1, 1'b0));
      send_neighbour(make_neighbour(32'h0000_0100, 32'h0, 40, -7, 1'b1, 1'b1));
      send_neighbour(make_neighbour(32'h1234_0000, 32'hFFFF_0000, 65536, 0, 1'b1, 1'b0));
      send_neighbour(make_neighbour(32'h1234_0000, 32'hFFFF_0000, 0, 0, 1'b0, 1'b0));
      send_neighbour(make_neighbour(32'h1234_0000, 32'hFFFF_0000, -30000, 90000, 1'b1,
                                    1'b1));
      // Extreme positions with a neighbour on the same spot.
      send_neighbour(make_neighbour(32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 1'b1, 1'b0));
      send_neighbour(make_neighbour(32'h8000_0000, 32'h8000_0000, 0, 0, 1'b1, 1'b1));
      write_register(sst_pkg::CSR_RADIUS, 64'h7FFF_FFFF);
      send_neighbour(make_neighbour(32'h3FFF_FFFF, 32'hC000_0001, 64'h7FFF_FFFE, 0, 1'b1,
                                    1'b1));
      send_neighbour(make_neighbour(32'h8000_0000, 32'h7FFF_FFFF, -131071, 131071, 1'b1,
                                    1'b1));
      // A zero threshold lets a one-step offset through as a huge sum.
      write_register(sst_pkg::CSR_THRESHOLD, 0);
      send_neighbour(make_neighbour(32'h0, 32'h0, 1, 0, 1'b1, 1'b0));
      send_neighbour(make_neighbour(32'h0, 32'h0, 0, -1, 1'b1, 1'b1));
      write_register(sst_pkg::CSR_THRESHOLD, 16'hFFFF);
      write_register(sst_pkg::CSR_STRENGTH, 64'h7FFF_FFFF);
      send_neighbour(make_neighbour(32'h5555_5555, 32'hAAAA_AAAA, 3000000, 2000, 1'b1,
                                    1'b1));
      send_neighbour(make_neighbour(32'h0, 32'h0, 100, 100, 1'b1, 1'b1));
      write_register(sst_pkg::CSR_RADIUS, 0);
      send_neighbour(make_neighbour(32'h0, 32'h0, 0, 0, 1'b1, 1'b1));
      send_neighbour(make_neighbour(32'h0, 32'h0, 5000, 0, 1'b1, 1'b1));
      wait_drained();
   endtask

   // The receiver stops for a long stretch while single-item runs keep
   // coming, so that the block fills and stalls its input.
   task automatic test_receiver_hold();
      hold_requests++;
      for (int i = 0; i < 30; i++) send_random_run(1);
      wait_drained();
   endtask

   // The sender stops until every result has come back, then resumes.
   task automatic test_sender_pause();
      test_random_runs(40);
      release_input();
      while (steer_expected.size() != 0) @(posedge clock);
      test_random_runs(40);
      wait_drained();
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      req_tlast = 1'b0;
      rsp_tready = 1'b0;
      csr_we = 1'b0;
      csr_addr = '0;
      csr_wdata = '0;
      no_idle = 1'b0;
      hold_requests = 0;
      holds_served = 0;
      hold_left = 0;
      error_count = 0;
      items_sent = 0;
      results_checked = 0;
      runs_sent = 0;
      radius_q = sst_pkg::RADIUS_RST;
      strength_q = sst_pkg::STRENGTH_RST;
      threshold_q = sst_pkg::THRESH_RST;
      sum_x_q = 0;
      sum_z_q = 0;
      parity_q = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_random_runs(150);
      test_directed();
      write_register(sst_pkg::CSR_RADIUS, 64'h7FFF_FFFF);
      write_register(sst_pkg::CSR_STRENGTH, 64'd65536);
      write_register(sst_pkg::CSR_THRESHOLD, 64'd66);
      test_random_runs(200);
      write_register(sst_pkg::CSR_RADIUS, 0);
      test_random_runs(50);
      write_register(sst_pkg::CSR_RADIUS, 64'd4096);
      write_register(sst_pkg::CSR_THRESHOLD, 0);
      write_register(sst_pkg::CSR_STRENGTH, 64'h7FFF_FFFF);
      test_random_runs(200);
      write_register(sst_pkg::CSR_RADIUS, 64'd1 << 20);
      write_register(sst_pkg::CSR_THRESHOLD, 64'hFFFF);
      write_register(sst_pkg::CSR_STRENGTH, 64'd1);
      test_random_runs(150);
      write_register(sst_pkg::CSR_RADIUS, 64'd131072);
      write_register(sst_pkg::CSR_STRENGTH, 64'd65536);
      write_register(sst_pkg::CSR_THRESHOLD, 64'd66);
      // A stretch with no idling on either side.
      no_idle = 1'b1;
      test_random_runs(150);
      no_idle = 1'b0;
      test_receiver_hold();
      test_sender_pause();
      test_random_runs(150);
      wait_drained();

      $display("Sent %0d neighbour transfers in %0d runs and checked %0d results",
               items_sent, runs_sent, results_checked);
      $display("over six register settings, a receiver hold-off and a drained pause.");
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sst_pkg.sv
rtl/sst_div.sv
rtl/sst_sqrt.sv
rtl/sst_datapath.sv
rtl/sst_ctrl.sv
rtl/separation_steering_accumulator.sv
verif/separation_steering_accumulator_tb.sv
